// File: hw/rtl/phe_pkg.sv
// phe_pkg: shared constants, opcodes and controller/datapath types
// for the pixel histogram engine. No dependencies.
`default_nettype none
package phe_pkg;

  // Storage geometry
  localparam int COUNT_BITS = 19;
  localparam int LEVELS     = 256;
  localparam int ADDR_BITS  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Fixed field widths of the channels
  localparam int OP_BITS    = 2;
  localparam int FIELD_BITS = 8;
  localparam int OUT_BITS   = 19;

  localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;

  // Opcodes
  localparam logic [OP_BITS-1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ       = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR      = 2'd2;

  typedef logic [OP_BITS-1:0]    opcode_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;     // latch request, issue bin read
    logic clear_all;   // drop every bin back to zero
    logic write_back;  // accumulate: write incremented count
    logic load_out;    // read: load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;    // result register empty or being taken this cycle
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/phe_req_if.sv
// phe_req_if: request channel of the histogram engine (valid/ready + fields).
// Depends on phe_pkg.
`default_nettype none
interface phe_req_if;
  logic                             valid;
  logic                             ready;
  logic [phe_pkg::OP_BITS-1:0]      opcode;
  logic [phe_pkg::FIELD_BITS-1:0]   pixel_value;
  logic [phe_pkg::FIELD_BITS-1:0]   bin_index;

  modport source (output valid, output opcode, output pixel_value, output bin_index,
                  input ready);
  modport sink   (input valid, input opcode, input pixel_value, input bin_index,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/phe_rsp_if.sv
// phe_rsp_if: result channel of the histogram engine (valid/ready + fields).
// Depends on phe_pkg.
`default_nettype none
interface phe_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [phe_pkg::OUT_BITS-1:0]   bin_count;
  logic                           saturated;

  modport source (output valid, output bin_count, output saturated, input ready);
  modport sink   (input valid, input bin_count, input saturated, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/phe_datapath.sv
// phe_datapath: bin memory, per-bin valid bits, saturating increment and
// result register. Depends on phe_pkg.
`default_nettype none
module phe_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire phe_pkg::cmd_t                    cmd,
  output phe_pkg::status_t                      status,
  input  wire logic [phe_pkg::OP_BITS-1:0]      opcode,
  input  wire logic [phe_pkg::FIELD_BITS-1:0]   pixel_value,
  input  wire logic [phe_pkg::FIELD_BITS-1:0]   bin_index,
  input  wire logic                             rsp_ready,
  output logic                                  rsp_valid,
  output logic [phe_pkg::OUT_BITS-1:0]          bin_count,
  output logic                                  saturated
);

  phe_pkg::count_t                mem [phe_pkg::LEVELS];
  logic [phe_pkg::LEVELS-1:0]     bin_valid;

  logic [phe_pkg::FIELD_BITS-1:0] sel_index;
  logic                           sel_in_range;
  phe_pkg::addr_t                 rd_addr;

  phe_pkg::addr_t                 addr_q;
  logic                           in_range_q;
  logic                           hit_q;
  phe_pkg::count_t                rdata;

  phe_pkg::count_t                cur_count;
  logic                           do_inc;

  assign sel_index    = (opcode == phe_pkg::OP_READ) ? bin_index : pixel_value;
  assign sel_in_range = (32'(sel_index) < 32'(phe_pkg::LEVELS));
  assign rd_addr      = phe_pkg::ADDR_BITS'(sel_index);

  // Entries never written since the last clear read as zero
  assign cur_count = hit_q ? rdata : '0;
  assign do_inc    = cmd.write_back && in_range_q && (cur_count != phe_pkg::COUNT_CEIL);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata      <= mem[rd_addr];
      addr_q     <= rd_addr;
      in_range_q <= sel_in_range;
    end
    if (do_inc) begin
      mem[addr_q] <= cur_count + phe_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      bin_valid <= '0;
    end else if (do_inc) begin
      bin_valid[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_q <= bin_valid[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bin_count <= in_range_q ? phe_pkg::OUT_BITS'(cur_count) : '0;
      saturated <= in_range_q && (cur_count == phe_pkg::COUNT_CEIL);
    end
  end

  assign status.out_free = !rsp_valid || rsp_ready;

endmodule
`default_nettype wire

// File: hw/rtl/phe_ctrl.sv
// phe_ctrl: two-state sequencer that accepts one request, then runs an accumulate's
// read-modify-write or a read's result load; other opcodes need none. Depends on phe_pkg.
`default_nettype none
module phe_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  input  wire logic [phe_pkg::OP_BITS-1:0]  req_opcode,
  output logic                              req_ready,
  input  wire phe_pkg::status_t             status,
  output phe_pkg::cmd_t                     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state;
  logic              state_next;
  phe_pkg::opcode_t  op_q;
  logic              accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.capture    = accept && ((req_opcode == phe_pkg::OP_ACCUMULATE) ||
                                (req_opcode == phe_pkg::OP_READ));
    cmd.clear_all  = accept && (req_opcode == phe_pkg::OP_CLEAR);
    cmd.write_back = (state == ST_EXEC) && (op_q == phe_pkg::OP_ACCUMULATE);
    cmd.load_out   = (state == ST_EXEC) && (op_q == phe_pkg::OP_READ) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.write_back || cmd.load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= req_opcode;
    end
  end

  a_capture_enters_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_EXEC))
    else $error("captured request did not start execution");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded while result register still held");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_back && cmd.load_out))
    else $error("write back and result load in the same cycle");

  a_accum_one_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.write_back |=> (state == ST_IDLE))
    else $error("accumulate stayed in execution");

endmodule
`default_nettype wire

// File: hw/rtl/pixel_histogram_engine_unit.sv
// pixel_histogram_engine_unit: top level of the grey-level histogram engine.
// Depends on phe_pkg, phe_req_if, phe_rsp_if, phe_ctrl, phe_datapath.
`default_nettype none
//
//  Channel  Dir  Handshake    Payload
//  req      in   valid/ready  opcode[1:0], pixel_value[7:0], bin_index[7:0]
//  rsp      out  valid/ready  bin_count[18:0], saturated
//
//  Accumulate and read requests first read the bin memory (registered read port),
//  then write back the increment or load the result.
//  Clear and unused opcodes end on acceptance; clear drops all per-bin valid bits at once.
//  Reset clears the valid bits, so all bins read as zero; no clearing pass.
//  A read waits in execution while a previous result is still held on rsp;
//  req.ready is low for that time.
module pixel_histogram_engine_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  phe_req_if.sink    req,
  phe_rsp_if.source  rsp
);

  phe_pkg::cmd_t    cmd;     // sequencer commands to the datapath
  phe_pkg::status_t status;  // result-register state back to the sequencer

  // Sequencer: owns req.ready and the per-request step
  phe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: bin memory, saturating increment, output register
  phe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (req.opcode),
    .pixel_value (req.pixel_value),
    .bin_index   (req.bin_index),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .bin_count   (rsp.bin_count),
    .saturated   (rsp.saturated)
  );

endmodule
`default_nettype wire
